// ===== rtl/igfr_pkg.sv =====
// igfr_pkg: shared types and constants of the idle gap frame receiver
// no dependencies; used by every module under rtl/
`default_nettype none

package igfr_pkg;

    // frame and slot geometry
    localparam int FRAME_BYTES = 256;
    localparam int SLOTS       = 4;
    localparam int BANKS       = SLOTS + 1;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int BANK_W      = $clog2(BANKS);
    localparam int ADDR_W      = $clog2(BANKS * FRAME_BYTES);

    // beat field widths
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int RSLOT_W    = 2;
    localparam int ROFF_W     = 8;
    localparam int FSLOT_W    = 2;
    localparam int FLEN_W     = 9;
    localparam int LIMIT_W    = 16;
    localparam int IDLE_W     = LIMIT_W + 1;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10;

    // command codes on the input tuser
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // result kinds on the output tuser
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_TICK,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [BYTE_W-1:0]    rx_byte;
        logic [RSLOT_W-1:0]   read_slot;
        logic [ROFF_W-1:0]    read_offset;
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RD_WAIT
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/igfr_front.sv =====
// igfr_front: accepts input beats and classifies them into queue operations
// depends on igfr_pkg
`default_nettype none

module igfr_front (
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [igfr_pkg::S_DATA_W-1:0] s_tdata,  // rx_byte, read_slot, read_offset
    input  wire logic [igfr_pkg::CMD_W-1:0]   s_tuser,   // cmd
    input  wire logic                         q_full,
    output logic                              q_push,
    output igfr_pkg::op_t                     q_op
);

    logic beat;
    logic known;

    // input is taken whenever the queue has room; unused commands vanish here
    assign s_tready = !q_full;
    assign beat     = s_tvalid && s_tready;

    // unpack payload fields and decode the command into an operation
    always_comb begin
        known            = 1'b1;
        q_op.kind        = igfr_pkg::OP_BYTE;
        q_op.rx_byte     = s_tdata[igfr_pkg::BYTE_W-1:0];
        q_op.read_slot   = s_tdata[igfr_pkg::BYTE_W +: igfr_pkg::RSLOT_W];
        q_op.read_offset = s_tdata[igfr_pkg::BYTE_W + igfr_pkg::RSLOT_W +: igfr_pkg::ROFF_W];
        unique case (s_tuser)
            igfr_pkg::CMD_BYTE: q_op.kind = igfr_pkg::OP_BYTE;
            igfr_pkg::CMD_TICK: q_op.kind = igfr_pkg::OP_TICK;
            igfr_pkg::CMD_READ: q_op.kind = igfr_pkg::OP_READ;
            default:            known     = 1'b0;
        endcase
    end

    assign q_push = beat && known;

endmodule

`default_nettype wire

// ===== rtl/igfr_fifo.sv =====
// igfr_fifo: short operation queue between the front and the back
// depends on igfr_pkg
`default_nettype none

module igfr_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  igfr_pkg::op_t      push_op,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output igfr_pkg::op_t      head_op
);

    igfr_pkg::op_t                  entry_reg [igfr_pkg::QDEPTH];
    logic [igfr_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [igfr_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [igfr_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == igfr_pkg::QCNT_W'(igfr_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == igfr_pkg::QPTR_W'(igfr_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == igfr_pkg::QPTR_W'(igfr_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= igfr_pkg::QCNT_W'(igfr_pkg::QDEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/igfr_back.sv =====
// igfr_back: executes queued operations, owns the frame banks and the result register
// depends on igfr_pkg
`default_nettype none

module igfr_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [igfr_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  wire logic                           q_not_empty,
    input  igfr_pkg::op_t                       q_head,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [igfr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tuser
);

    localparam int F_BYTES = igfr_pkg::FRAME_BYTES;

    // bank memory: one spare bank collects, the others hold completed frames
    logic [7:0] bank_mem [igfr_pkg::BANKS * F_BYTES];

    igfr_pkg::back_state_t              state_reg, state_next;
    logic [igfr_pkg::LIMIT_W-1:0]       limit_reg;
    logic [igfr_pkg::LEN_W-1:0]         count_reg, count_next;
    logic [igfr_pkg::IDLE_W-1:0]        idle_reg, idle_next;
    logic                               receiving_reg, receiving_next;
    logic [igfr_pkg::SLOT_W-1:0]        ptr_reg, ptr_next;
    logic [igfr_pkg::BANK_W-1:0]        free_bank_reg, free_bank_next;
    logic [igfr_pkg::BANK_W-1:0]        map_reg [igfr_pkg::SLOTS];
    logic [igfr_pkg::LEN_W-1:0]         len_reg [igfr_pkg::SLOTS];
    logic                               hit_reg, hit_next;
    logic [7:0]                         rd_data_reg;
    logic                               m_valid_reg, m_valid_next;
    logic                               kind_reg;
    logic [igfr_pkg::FSLOT_W-1:0]       fslot_reg;
    logic [igfr_pkg::FLEN_W-1:0]        flen_reg;
    logic [7:0]                         data_reg;

    logic                               out_free;
    logic                               out_load;
    logic                               out_kind;
    logic [igfr_pkg::FSLOT_W-1:0]       out_fslot;
    logic [igfr_pkg::FLEN_W-1:0]        out_flen;
    logic [7:0]                         out_data;
    logic                               done_fire;
    logic [igfr_pkg::SLOT_W-1:0]        next_ptr;
    logic [igfr_pkg::SLOT_W-1:0]        tab_addr;
    logic [igfr_pkg::BANK_W-1:0]        tab_bank;
    logic [igfr_pkg::LEN_W-1:0]         tab_len;
    logic [igfr_pkg::IDLE_W-1:0]        idle_inc;
    logic                               mem_we;
    logic [igfr_pkg::ADDR_W-1:0]        wr_addr;
    logic                               rd_en;
    logic [igfr_pkg::ADDR_W-1:0]        rd_addr;

    // next slot after the current pointer, wrapping at the slot count
    assign next_ptr = ({1'b0, ptr_reg} + 1'b1 < (igfr_pkg::SLOT_W + 1)'(igfr_pkg::SLOTS))
                    ? ptr_reg + 1'b1 : '0;

    // one shared lookup into the slot tables: read slot or completion slot
    assign tab_addr = (q_head.kind == igfr_pkg::OP_READ)
                    ? igfr_pkg::SLOT_W'(q_head.read_slot) : next_ptr;
    assign tab_bank = map_reg[tab_addr];
    assign tab_len  = len_reg[tab_addr];

    assign idle_inc = idle_reg + 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    // bank addresses
    assign wr_addr = igfr_pkg::ADDR_W'(free_bank_reg) * igfr_pkg::ADDR_W'(F_BYTES)
                   + igfr_pkg::ADDR_W'(count_reg[igfr_pkg::IDX_W-1:0]);
    assign rd_addr = igfr_pkg::ADDR_W'(tab_bank) * igfr_pkg::ADDR_W'(F_BYTES)
                   + igfr_pkg::ADDR_W'(q_head.read_offset[igfr_pkg::IDX_W-1:0]);

    // sequencer: next state and operation effects
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idle_next      = idle_reg;
        receiving_next = receiving_reg;
        ptr_next       = ptr_reg;
        free_bank_next = free_bank_reg;
        hit_next       = hit_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        out_load       = 1'b0;
        done_fire      = 1'b0;
        out_kind       = igfr_pkg::KIND_DONE;
        out_fslot      = '0;
        out_flen       = '0;
        out_data       = '0;
        unique case (state_reg)
            igfr_pkg::ST_IDLE: begin
                if (q_not_empty) begin
                    unique case (q_head.kind)
                        igfr_pkg::OP_BYTE: begin
                            q_pop = 1'b1;
                            if (count_reg < igfr_pkg::LEN_W'(F_BYTES)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            receiving_next = 1'b1;
                            idle_next      = '0;
                        end
                        igfr_pkg::OP_TICK: begin
                            if (out_free) begin
                                q_pop = 1'b1;
                                if (receiving_reg) begin
                                    if (idle_inc > igfr_pkg::IDLE_W'(limit_reg)) begin
                                        // frame ends: swap collect bank into the next slot
                                        done_fire      = 1'b1;
                                        ptr_next       = next_ptr;
                                        free_bank_next = tab_bank;
                                        count_next     = '0;
                                        receiving_next = 1'b0;
                                        idle_next      = '0;
                                        out_load       = 1'b1;
                                        out_kind       = igfr_pkg::KIND_DONE;
                                        out_fslot      = igfr_pkg::FSLOT_W'(next_ptr);
                                        out_flen       = igfr_pkg::FLEN_W'(count_reg);
                                    end else begin
                                        idle_next = idle_inc;
                                    end
                                end
                            end
                        end
                        igfr_pkg::OP_READ: begin
                            q_pop      = 1'b1;
                            rd_en      = 1'b1;
                            hit_next   = ((igfr_pkg::RSLOT_W + 1)'(q_head.read_slot)
                                          < (igfr_pkg::RSLOT_W + 1)'(igfr_pkg::SLOTS))
                                       && (igfr_pkg::LEN_W'(q_head.read_offset) < tab_len);
                            state_next = igfr_pkg::ST_RD_WAIT;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            igfr_pkg::ST_RD_WAIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = igfr_pkg::KIND_READ;
                    out_data   = hit_reg ? rd_data_reg : 8'd0;
                    state_next = igfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = igfr_pkg::ST_IDLE;
            end
        endcase
    end

    // result valid
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= igfr_pkg::ST_IDLE;
            limit_reg     <= igfr_pkg::LIMIT_RESET;
            count_reg     <= '0;
            idle_reg      <= '0;
            receiving_reg <= 1'b0;
            ptr_reg       <= '0;
            free_bank_reg <= igfr_pkg::BANK_W'(igfr_pkg::SLOTS);
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < igfr_pkg::SLOTS; i++) begin
                map_reg[i] <= igfr_pkg::BANK_W'(i);
                len_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            receiving_reg <= receiving_next;
            ptr_reg       <= ptr_next;
            free_bank_reg <= free_bank_next;
            hit_reg       <= hit_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (done_fire) begin
                map_reg[next_ptr] <= free_bank_reg;
                len_reg[next_ptr] <= count_reg;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg  <= out_kind;
            fslot_reg <= out_fslot;
            flen_reg  <= out_flen;
            data_reg  <= out_data;
        end
    end

    // bank memory write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bank_mem[wr_addr] <= q_head.rx_byte;
        end
        if (rd_en) begin
            rd_data_reg <= bank_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = igfr_pkg::M_DATA_W'({data_reg, flen_reg, fslot_reg});

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= igfr_pkg::LEN_W'(F_BYTES))
        else $error("collect count beyond frame size");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        done_fire |=> (!receiving_reg && count_reg == '0 && m_valid_reg))
        else $error("frame end did not clear collect state");

    a_bank_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        free_bank_reg != map_reg[ptr_reg])
        else $error("collect bank aliases a stored slot");

    a_read_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == igfr_pkg::ST_RD_WAIT && out_free)
        |=> (m_valid_reg && kind_reg == igfr_pkg::KIND_READ))
        else $error("read reply not presented");

endmodule

`default_nettype wire

// ===== rtl/idle_gap_frame_receiver_unit.sv =====
// idle_gap_frame_receiver_unit: top level of the idle gap frame receiver
// depends on igfr_pkg, igfr_front, igfr_fifo, igfr_back
//
//  channel   | direction | payload
//  s_*       | in        | tuser cmd; tdata rx_byte, read_slot, read_offset
//  m_*       | out       | tuser kind; tdata frame_slot, frame_length, read_data
//  cfg_wr_*  | in        | idle_limit, written when cfg_wr_en is high
//
//  a beat passes the front in the cycle it is taken and waits in a two entry queue
//  the back executes a byte or a tick from the idle state; a read also passes the wait state (registered bank read)
//  frame end swaps the collect bank into the next slot, so no byte copy takes place
//  reset is synchronous; no clearing pass, slot lengths reset to zero
//  a full queue stalls input; a stalled result holds the back only for ticks and reads
`default_nettype none

module idle_gap_frame_receiver_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [igfr_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [igfr_pkg::S_DATA_W-1:0]  s_tdata,   // rx_byte, read_slot, read_offset
    input  wire logic [igfr_pkg::CMD_W-1:0]     s_tuser,   // cmd
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [igfr_pkg::M_DATA_W-1:0]       m_tdata,   // frame_slot, frame_length, read_data
    output logic                                m_tuser    // kind
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    igfr_pkg::op_t  q_in;
    igfr_pkg::op_t  q_head;

    // front: accept and classify
    igfr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_in)
    );

    // operation queue
    igfr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_op   (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (q_head)
    );

    // back: execute and reply
    igfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
